// File: design/lattice_rotate_xor_checksum_assert.svh
// Assertion macros shared by the checksum block's modules.
// No dependencies; each file that asserts includes this header.
`ifndef LATTICE_ROTATE_XOR_CHECKSUM_ASSERT_SVH
`define LATTICE_ROTATE_XOR_CHECKSUM_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while reset is released.
`define LRXC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lrxc assertion failed");
// Checked at every edge, reset included.
`define LRXC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lrxc assertion failed");
`else
`define LRXC_ASSERT(label, clk, rst, prop)
`define LRXC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: design/lrxc_pkg.sv
// Package of the rotate-xor checksum block: payload and configuration types,
// register indexes and checksum constants. No dependencies.
`default_nettype none
package lrxc_pkg;

   localparam int unsigned WORD_WIDTH  = 32;
   localparam int unsigned ROT_WIDTH   = 5;
   localparam int unsigned CSR_IDX_WIDTH = 2;

   localparam logic [ROT_WIDTH-1:0] MOD_A = 5'd29;
   localparam logic [ROT_WIDTH-1:0] MOD_B = 5'd31;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_SWAP_BYTES     = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_EXPECTED_SUM_A = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_EXPECTED_SUM_B = 2'd2;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] data_word;
      logic                  final_word;
   } req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] word_out;
      logic [WORD_WIDTH-1:0] running_sum_a;
      logic [WORD_WIDTH-1:0] running_sum_b;
      logic                  pass_end;
      logic                  sums_match;
   } rsp_type;

   typedef struct packed {
      logic                  swap_bytes;
      logic [WORD_WIDTH-1:0] expected_sum_a;
      logic [WORD_WIDTH-1:0] expected_sum_b;
   } cfg_type;

endpackage
`default_nettype wire

// File: design/lrxc_csr.sv
// Configuration registers of the checksum block.
// Depends on lrxc_pkg.
`default_nettype none
module lrxc_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [lrxc_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [lrxc_pkg::WORD_WIDTH-1:0]       csr_write_data,
   output lrxc_pkg::cfg_type                          cfg
);

   lrxc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lrxc_pkg::REG_SWAP_BYTES:     cfg_in.swap_bytes     = csr_write_data[0];
            lrxc_pkg::REG_EXPECTED_SUM_A: cfg_in.expected_sum_a = csr_write_data;
            lrxc_pkg::REG_EXPECTED_SUM_B: cfg_in.expected_sum_b = csr_write_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: design/lrxc_mix.sv
// Checksum datapath: byte reversal, two rotate-xor accumulators and their
// rotation counters. Depends on lrxc_pkg and the assertion header.
`default_nettype none
`include "lattice_rotate_xor_checksum_assert.svh"
module lrxc_mix (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire lrxc_pkg::req_type item,
   input  wire lrxc_pkg::cfg_type cfg,
   output lrxc_pkg::rsp_type result
);

   localparam int unsigned W = lrxc_pkg::WORD_WIDTH;
   localparam int unsigned R = lrxc_pkg::ROT_WIDTH;

   logic [W-1:0] accum_a_ff, accum_a_in, accum_b_ff, accum_b_in;
   logic [R-1:0] rot_a_ff, rot_a_in, rot_b_ff, rot_b_in;
   logic [W-1:0] word, sum_a, sum_b;

   function automatic logic [W-1:0] rotl(input logic [W-1:0] v, input logic [R-1:0] r);
      logic [2*W-1:0] both;
      both = {v, v} << r;
      return both[2*W-1:W];
   endfunction

   function automatic logic [R-1:0] advance(input logic [R-1:0] r, input logic [R-1:0] m);
      return (r >= m - 5'd1) ? '0 : r + 5'd1;
   endfunction

   always_comb begin
      word = cfg.swap_bytes
         ? {item.data_word[7:0], item.data_word[15:8],
            item.data_word[23:16], item.data_word[31:24]}
         : item.data_word;
      sum_a = accum_a_ff ^ rotl(word, rot_a_ff);
      sum_b = accum_b_ff ^ rotl(word, rot_b_ff);

      result.word_out      = word;
      result.running_sum_a = sum_a;
      result.running_sum_b = sum_b;
      result.pass_end      = item.final_word;
      result.sums_match    = item.final_word && (sum_a == cfg.expected_sum_a)
                             && (sum_b == cfg.expected_sum_b);

      accum_a_in = accum_a_ff;
      accum_b_in = accum_b_ff;
      rot_a_in   = rot_a_ff;
      rot_b_in   = rot_b_ff;
      if (step) begin
         if (item.final_word) begin
            // The pass is closed: start the next one from a clean state.
            accum_a_in = '0;
            accum_b_in = '0;
            rot_a_in   = '0;
            rot_b_in   = '0;
         end else begin
            accum_a_in = sum_a;
            accum_b_in = sum_b;
            rot_a_in   = advance(rot_a_ff, lrxc_pkg::MOD_A);
            rot_b_in   = advance(rot_b_ff, lrxc_pkg::MOD_B);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_a_ff <= '0;
         accum_b_ff <= '0;
         rot_a_ff   <= '0;
         rot_b_ff   <= '0;
      end else begin
         accum_a_ff <= accum_a_in;
         accum_b_ff <= accum_b_in;
         rot_a_ff   <= rot_a_in;
         rot_b_ff   <= rot_b_in;
      end
   end

   `LRXC_ASSERT(a_rot_a_range, clock, reset, rot_a_ff < lrxc_pkg::MOD_A)
   `LRXC_ASSERT(a_rot_b_range, clock, reset, rot_b_ff < lrxc_pkg::MOD_B)
   `LRXC_ASSERT(a_pass_clears, clock, reset,
      step && item.final_word |=> rot_a_ff == '0 && rot_b_ff == '0
      && accum_a_ff == '0 && accum_b_ff == '0)

endmodule
`default_nettype wire

// File: design/lattice_rotate_xor_checksum.sv
// Top level of the rotate-xor checksum block: input register, datapath and
// result register. Depends on lrxc_pkg, lrxc_csr, lrxc_mix, assertion header.
//
// Usage: words arrive on the req_ channel (valid/ready), one transaction per
// 32-bit word, final_word marking the last word of a pass. Every transaction
// yields exactly one transaction on the rsp_ channel carrying the (optionally
// byte-reversed) word, both running sums including that word, the pass end
// flag and, at pass end, the match against the expected sums.
// Configuration is written through csr_write_enable/csr_index/csr_write_data
// while no transaction is in flight; a write takes effect at the next edge.
// Pipeline: an accepted word is held in the input register, then its result is
// captured in the result register, which drives rsp_valid and rsp_payload.
// Throughput: one word per cycle while the receiver takes every result; the
// accumulators take the rotate-xor update of each word as it moves on.
// Reset clears the configuration, both sums, both rotation counters and the
// pipeline. When the receiver stalls, the result register holds; the input
// register still takes one more word, after which req_ready drops until the
// result is taken.
`default_nettype none
`include "lattice_rotate_xor_checksum_assert.svh"
module lattice_rotate_xor_checksum (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire lrxc_pkg::req_type                  req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output lrxc_pkg::rsp_type                       rsp_payload,
   input  wire logic                               csr_write_enable,
   input  wire logic [lrxc_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [lrxc_pkg::WORD_WIDTH-1:0]    csr_write_data
);

   lrxc_pkg::cfg_type cfg;
   lrxc_pkg::req_type in_data_ff;
   lrxc_pkg::rsp_type out_data_ff, result;
   logic in_valid_ff, in_valid_in, out_valid_ff, out_valid_in;
   logic advance_item;

   lrxc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lrxc_mix u_mix (
      .clock  (clock),
      .reset  (reset),
      .step   (advance_item),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   // The held word moves on whenever the result register is free or drains.
   assign advance_item = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance_item;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance_item) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance_item) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (advance_item) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   `LRXC_ASSERT(a_stall_only_when_full, clock, reset,
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
   `LRXC_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> !rsp_valid && !in_valid_ff)
   `LRXC_ASSERT(a_match_only_at_end, clock, reset,
      rsp_valid && !rsp_payload.pass_end |-> !rsp_payload.sums_match)

endmodule
`default_nettype wire
